[design/meg_pkg.sv]
// ----------------------------------------------------------------------------
// meg_pkg: shared definitions for the midpoint ellipse generator
// Colour field widths, item function codes and the RGB565 packing helper.
// ----------------------------------------------------------------------------
package meg_pkg;

    // Colour channel and packed pixel widths
    localparam int COLOR_BITS = 8;
    localparam int PIXEL_BITS = 16;

    // Item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Pack an 8:8:8 colour into 5:6:5
    function automatic logic [PIXEL_BITS-1:0] pack565(
        input logic [COLOR_BITS-1:0] r,
        input logic [COLOR_BITS-1:0] g,
        input logic [COLOR_BITS-1:0] b
    );
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

[design/midpoint_ellipse_generator_core.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_generator_core
// Midpoint ellipse rasterizer built around one shared multiplier and one
// shared wide adder under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready): func = FUNC_START loads the centre,
//   semi-axes and colour; func = FUNC_STEP runs one iteration. item_ready is
//   high only while the sequencer is idle; one item is worked at a time.
//   Result channel (result_valid/result_ready): each item yields four mirrored
//   points in the order (+x,+y), (-x,+y), (+x,-y), (-x,-y), the fourth with
//   last set, or a single done result (zero coordinates, last and done_res).
//   Sequence from item transfer to the last point loaded into the output
//   register, per item kind:
//     start            : a^2, b^2, a^2*b, region 1 decision, then points
//     region 1 step    : x and dx, y and dy if d >= 0, decision, then points
//     region 2 step    : y and dy, decision, x and dx if d <= 0, then points
//     entering region 2: the multiplies of the new decision come first
//     done             : the single done result
//   The item rate is set by the sequence of multiplies and adds through the
//   shared unit plus one output register load per point.
//   A stalled receiver holds the output register; the sequencer waits at the
//   point it wants to load. The next item is taken while the last point of
//   the previous one still waits. Reset returns to idle; a step then gives
//   the done result.
// ----------------------------------------------------------------------------
module midpoint_ellipse_generator_core #(
    parameter int COORD_BITS = 12,
    parameter int AXIS_BITS  = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  func,
    input  logic signed [COORD_BITS-1:0]          center_x,
    input  logic signed [COORD_BITS-1:0]          center_y,
    input  logic        [AXIS_BITS-1:0]           semi_x,
    input  logic        [AXIS_BITS-1:0]           semi_y,
    input  logic        [meg_pkg::COLOR_BITS-1:0] red,
    input  logic        [meg_pkg::COLOR_BITS-1:0] green,
    input  logic        [meg_pkg::COLOR_BITS-1:0] blue,

    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [COORD_BITS:0]            point_x,
    output logic signed [COORD_BITS:0]            point_y,
    output logic        [meg_pkg::PIXEL_BITS-1:0] pixel565,
    output logic                                  last,
    output logic                                  done_res
);

    import meg_pkg::*;

    // Derived widths
    localparam int OB   = COORD_BITS + 1;           // output coordinate
    localparam int XW   = AXIS_BITS + 2;            // current x / y
    localparam int SQW  = 2 * AXIS_BITS;            // a^2, b^2
    localparam int MW   = 2 * AXIS_BITS + 6;        // multiplier operand
    localparam int PW   = 4 * AXIS_BITS + 6;        // kept product
    localparam int DW   = 4 * AXIS_BITS + 8;        // decision
    localparam int SW   = 3 * AXIS_BITS + 4;        // slopes
    localparam int SUMW = ((OB > XW) ? OB : XW) + 1; // point adder

    // Phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_R1   = 2'd1;
    localparam logic [1:0] PH_R2   = 2'd2;

    // Sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_L_AA  = 5'd1;
    localparam logic [4:0] ST_L_BB  = 5'd2;
    localparam logic [4:0] ST_L_AB  = 5'd3;
    localparam logic [4:0] ST_L_D0  = 5'd4;
    localparam logic [4:0] ST_L_D1  = 5'd5;
    localparam logic [4:0] ST_L_D2  = 5'd6;
    localparam logic [4:0] ST_L_DIV = 5'd7;
    localparam logic [4:0] ST_I_TX  = 5'd8;
    localparam logic [4:0] ST_I_BTX = 5'd9;
    localparam logic [4:0] ST_I_TY  = 5'd10;
    localparam logic [4:0] ST_I_ATY = 5'd11;
    localparam logic [4:0] ST_I_AD  = 5'd12;
    localparam logic [4:0] ST_I_SUB = 5'd13;
    localparam logic [4:0] ST_I_DIV = 5'd14;
    localparam logic [4:0] ST_R1_DX = 5'd15;
    localparam logic [4:0] ST_R1_DY = 5'd16;
    localparam logic [4:0] ST_R1_D1 = 5'd17;
    localparam logic [4:0] ST_R1_D2 = 5'd18;
    localparam logic [4:0] ST_R1_D3 = 5'd19;
    localparam logic [4:0] ST_R2_DY = 5'd20;
    localparam logic [4:0] ST_R2_D1 = 5'd21;
    localparam logic [4:0] ST_R2_D2 = 5'd22;
    localparam logic [4:0] ST_R2_DX = 5'd23;
    localparam logic [4:0] ST_R2_D3 = 5'd24;
    localparam logic [4:0] ST_EMIT  = 5'd25;
    localparam logic [4:0] ST_DONE  = 5'd26;

    // Control registers
    logic [4:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] k_reg, k_next;
    logic       br_reg, br_next;

    // Ellipse state
    logic signed [COORD_BITS-1:0] ccol_reg, ccol_next;
    logic signed [COORD_BITS-1:0] crow_reg, crow_next;
    logic [AXIS_BITS-1:0]         a_reg, a_next;
    logic [AXIS_BITS-1:0]         b_reg, b_next;
    logic [SQW-1:0]               a2_reg, a2_next;
    logic [SQW-1:0]               b2_reg, b2_next;
    logic [XW-1:0]                x_reg, x_next;
    logic [XW-1:0]                y_reg, y_next;
    logic signed [SW-1:0]         dx_reg, dx_next;
    logic signed [SW-1:0]         dy_reg, dy_next;
    logic signed [DW-1:0]         d_reg, d_next;
    logic [PW-1:0]                prod_reg, prod_next;
    logic [PIXEL_BITS-1:0]        color_reg, color_next;

    // Output register
    logic                  rv_reg, rv_next;
    logic [OB-1:0]         px_reg, px_next;
    logic [OB-1:0]         py_reg, py_next;
    logic [PIXEL_BITS-1:0] pix_reg, pix_next;
    logic                  last_reg, last_next;
    logic                  done_reg, done_next;

    // Shared unit
    logic [MW-1:0]        mul_a, mul_b;
    logic [2*MW-1:0]      mul_res;
    logic                 mul_en;
    logic signed [DW-1:0] add_a, add_b, add_res;
    logic                 add_sub;

    // Helpers
    logic                  accept;
    logic                  space;
    logic [XW:0]           tx;
    logic [XW-1:0]         ty;
    logic signed [SUMW-1:0] cx_ext, cy_ext, x_ext, y_ext, px_calc, py_calc;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign space      = !rv_reg || result_ready;

    // Region 2 multiplier terms: 2x+1 and |y-1|
    assign tx = {x_reg, 1'b1};
    assign ty = (y_reg == '0) ? XW'(1) : y_reg - XW'(1);

    // Shared multiplier and adder
    assign mul_res = mul_a * mul_b;
    assign add_res = add_a + (add_sub ? ~add_b : add_b) + DW'(add_sub);

    // Mirrored point arithmetic
    assign cx_ext  = SUMW'(ccol_reg);
    assign cy_ext  = SUMW'(crow_reg);
    assign x_ext   = SUMW'($signed({1'b0, x_reg}));
    assign y_ext   = SUMW'($signed({1'b0, y_reg}));
    assign px_calc = k_reg[0] ? cx_ext - x_ext : cx_ext + x_ext;
    assign py_calc = k_reg[1] ? cy_ext - y_ext : cy_ext + y_ext;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        br_next    = br_reg;
        ccol_next  = ccol_reg;
        crow_next  = crow_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        a2_next    = a2_reg;
        b2_next    = b2_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;
        color_next = color_reg;
        rv_next    = rv_reg && !result_ready;
        px_next    = px_reg;
        py_next    = py_reg;
        pix_next   = pix_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        mul_a      = '0;
        mul_b      = '0;
        mul_en     = 1'b0;
        add_a      = '0;
        add_b      = '0;
        add_sub    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_START)
                    begin
                        ccol_next  = center_x;
                        crow_next  = center_y;
                        a_next     = semi_x;
                        b_next     = semi_y;
                        x_next     = '0;
                        y_next     = XW'(semi_y);
                        dx_next    = '0;
                        color_next = pack565(red, green, blue);
                        phase_next = PH_R1;
                        state_next = ST_L_AA;
                    end
                    else if (phase_reg == PH_R1 && dx_reg < dy_reg)
                    begin
                        state_next = ST_R1_DX;
                    end
                    else if (phase_reg == PH_R1)
                    begin
                        state_next = ST_I_TX;
                    end
                    else if (phase_reg == PH_R2 && y_reg != '0)
                    begin
                        state_next = ST_R2_DY;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            // Start: a^2, b^2, a^2*b and the region 1 decision
            ST_L_AA:
            begin
                mul_a      = MW'(a_reg);
                mul_b      = MW'(a_reg);
                mul_en     = 1'b1;
                state_next = ST_L_BB;
            end
            ST_L_BB:
            begin
                a2_next    = prod_reg[SQW-1:0];
                mul_a      = MW'(b_reg);
                mul_b      = MW'(b_reg);
                mul_en     = 1'b1;
                state_next = ST_L_AB;
            end
            ST_L_AB:
            begin
                b2_next    = prod_reg[SQW-1:0];
                mul_a      = MW'(a2_reg);
                mul_b      = MW'(b_reg);
                mul_en     = 1'b1;
                state_next = ST_L_D0;
            end
            ST_L_D0:
            begin
                dy_next    = SW'({prod_reg, 1'b0});
                add_a      = DW'({b2_reg, 2'b00});
                add_b      = DW'({prod_reg, 2'b00});
                add_sub    = 1'b1;
                d_next     = add_res;
                state_next = ST_L_D1;
            end
            ST_L_D1:
            begin
                add_a      = d_reg;
                add_b      = DW'(a2_reg);
                d_next     = add_res;
                state_next = ST_L_D2;
            end
            ST_L_D2:
            begin
                add_a      = d_reg;
                add_b      = DW'(2);
                d_next     = add_res;
                state_next = ST_L_DIV;
            end
            ST_L_DIV:
            begin
                // quarter units, truncated toward zero
                add_a      = d_reg;
                add_b      = d_reg[DW-1] ? DW'(3) : '0;
                d_next     = add_res >>> 2;
                state_next = ST_EMIT;
            end

            // Region 2 entry: b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2b^2 - 2
            ST_I_TX:
            begin
                mul_a      = MW'(tx);
                mul_b      = MW'(tx);
                mul_en     = 1'b1;
                state_next = ST_I_BTX;
            end
            ST_I_BTX:
            begin
                mul_a      = MW'(b2_reg);
                mul_b      = prod_reg[MW-1:0];
                mul_en     = 1'b1;
                state_next = ST_I_TY;
            end
            ST_I_TY:
            begin
                add_a      = DW'(prod_reg);
                add_b      = DW'(2);
                add_sub    = 1'b1;
                d_next     = add_res;
                mul_a      = MW'(ty);
                mul_b      = MW'(ty);
                mul_en     = 1'b1;
                state_next = ST_I_ATY;
            end
            ST_I_ATY:
            begin
                mul_a      = MW'(a2_reg);
                mul_b      = prod_reg[MW-1:0];
                mul_en     = 1'b1;
                state_next = ST_I_AD;
            end
            ST_I_AD:
            begin
                add_a      = d_reg;
                add_b      = DW'({prod_reg, 2'b00});
                d_next     = add_res;
                mul_a      = MW'(a2_reg);
                mul_b      = MW'(b2_reg);
                mul_en     = 1'b1;
                state_next = ST_I_SUB;
            end
            ST_I_SUB:
            begin
                add_a      = d_reg;
                add_b      = DW'({prod_reg, 2'b00});
                add_sub    = 1'b1;
                d_next     = add_res;
                state_next = ST_I_DIV;
            end
            ST_I_DIV:
            begin
                add_a      = d_reg;
                add_b      = d_reg[DW-1] ? DW'(3) : '0;
                d_next     = add_res >>> 2;
                phase_next = PH_R2;
                state_next = (y_reg != '0) ? ST_R2_DY : ST_DONE;
            end

            // Region 1 iteration
            ST_R1_DX:
            begin
                x_next     = x_reg + XW'(1);
                add_a      = DW'(dx_reg);
                add_b      = DW'({b2_reg, 1'b0});
                dx_next    = add_res[SW-1:0];
                br_next    = d_reg[DW-1];
                state_next = d_reg[DW-1] ? ST_R1_D1 : ST_R1_DY;
            end
            ST_R1_DY:
            begin
                y_next     = y_reg - XW'(1);
                add_a      = DW'(dy_reg);
                add_b      = DW'({a2_reg, 1'b0});
                add_sub    = 1'b1;
                dy_next    = add_res[SW-1:0];
                state_next = ST_R1_D1;
            end
            ST_R1_D1:
            begin
                add_a      = d_reg;
                add_b      = DW'(b2_reg);
                d_next     = add_res;
                state_next = ST_R1_D2;
            end
            ST_R1_D2:
            begin
                add_a      = d_reg;
                add_b      = DW'(dx_reg);
                d_next     = add_res;
                state_next = br_reg ? ST_EMIT : ST_R1_D3;
            end
            ST_R1_D3:
            begin
                add_a      = d_reg;
                add_b      = DW'(dy_reg);
                add_sub    = 1'b1;
                d_next     = add_res;
                state_next = ST_EMIT;
            end

            // Region 2 iteration
            ST_R2_DY:
            begin
                y_next     = y_reg - XW'(1);
                add_a      = DW'(dy_reg);
                add_b      = DW'({a2_reg, 1'b0});
                add_sub    = 1'b1;
                dy_next    = add_res[SW-1:0];
                br_next    = !d_reg[DW-1] && (d_reg != '0);
                state_next = ST_R2_D1;
            end
            ST_R2_D1:
            begin
                add_a      = d_reg;
                add_b      = DW'(a2_reg);
                d_next     = add_res;
                state_next = ST_R2_D2;
            end
            ST_R2_D2:
            begin
                add_a      = d_reg;
                add_b      = DW'(dy_reg);
                add_sub    = 1'b1;
                d_next     = add_res;
                state_next = br_reg ? ST_EMIT : ST_R2_DX;
            end
            ST_R2_DX:
            begin
                x_next     = x_reg + XW'(1);
                add_a      = DW'(dx_reg);
                add_b      = DW'({b2_reg, 1'b0});
                dx_next    = add_res[SW-1:0];
                state_next = ST_R2_D3;
            end
            ST_R2_D3:
            begin
                add_a      = d_reg;
                add_b      = DW'(dx_reg);
                d_next     = add_res;
                state_next = ST_EMIT;
            end

            // Four mirrored points, one per output register load
            ST_EMIT:
            begin
                if (space)
                begin
                    rv_next   = 1'b1;
                    px_next   = px_calc[OB-1:0];
                    py_next   = py_calc[OB-1:0];
                    pix_next  = color_reg;
                    last_next = (k_reg == 2'd3);
                    done_next = 1'b0;
                    k_next    = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Single done result
            ST_DONE:
            begin
                if (space)
                begin
                    rv_next    = 1'b1;
                    px_next    = '0;
                    py_next    = '0;
                    pix_next   = '0;
                    last_next  = 1'b1;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mul_en)
        begin
            prod_next = mul_res[PW-1:0];
        end
    end

    // Registers with reset: control, ellipse state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            k_reg     <= '0;
            br_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            ccol_reg  <= '0;
            crow_reg  <= '0;
            a2_reg    <= '0;
            b2_reg    <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            d_reg     <= '0;
            color_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            br_reg    <= br_next;
            rv_reg    <= rv_next;
            ccol_reg  <= ccol_next;
            crow_reg  <= crow_next;
            a2_reg    <= a2_next;
            b2_reg    <= b2_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            d_reg     <= d_next;
            color_reg <= color_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pix_reg  <= pix_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign result_valid = rv_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign pixel565     = pix_reg;
    assign last         = last_reg;
    assign done_res     = done_reg;

    // Checks
    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_START) |=> state_reg == ST_L_AA)
        else $error("start transfer did not enter the load sequence");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && done_res |-> point_x == '0 && point_y == '0
            && pixel565 == '0 && last)
        else $error("done result carries data");

    a_dy_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !dy_reg[SW-1])
        else $error("slope dy went negative");

    a_k_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_EMIT |-> k_reg == 2'd0)
        else $error("point counter left mid-sequence");

endmodule
